// ----- sv/kmp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kmp_pkg;

   // Window depth and position counter width
   localparam int PATTERN_BYTES = 16;
   localparam int POSITION_BITS = 32;

   // Pattern bytes held by the configuration registers
   localparam int CFG_BYTES = 16;
   localparam int CAP_BYTES = (PATTERN_BYTES < CFG_BYTES) ? PATTERN_BYTES : CFG_BYTES;

   localparam int LEN_BITS  = 5;
   localparam int SPAN_BITS = $clog2(CFG_BYTES);
   localparam int CNT_BITS  = $clog2(PATTERN_BYTES + 1);
   localparam int MATCH_BITS = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 64;

   typedef logic [7:0] byte_type;
   typedef byte_type [PATTERN_BYTES-1:0] window_type;
   typedef byte_type [CFG_BYTES-1:0] pattern_type;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PATTERN_LOW  = 2'd0,
      CSR_PATTERN_HIGH = 2'd1,
      CSR_PATTERN_LEN  = 2'd2
   } csr_index_type;

   // Outcome of one window compare
   typedef struct packed {
      logic                 hit;
      logic [SPAN_BITS-1:0] span;
   } match_status_type;

endpackage

`default_nettype wire

// ----- sv/kmp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface kmp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       text_start;

   modport source (output valid, output text_byte, output text_start, input ready);
   modport sink (input valid, input text_byte, input text_start, output ready);
endinterface

interface kmp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] match_start;

   modport source (output valid, output match_start, input ready);
   modport sink (input valid, input match_start, output ready);
endinterface

interface kmp_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reg_index;
   logic [63:0] wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- sv/kmp_window_match.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kmp_window_match (
   input  kmp_pkg::window_type       window,
   input  logic [kmp_pkg::CNT_BITS-1:0] fill_count,
   input  kmp_pkg::pattern_type      pattern,
   input  logic [kmp_pkg::LEN_BITS-1:0] length_raw,
   output kmp_pkg::match_status_type status
);
   import kmp_pkg::*;

   logic [LEN_BITS-1:0]  used_len;
   logic [SPAN_BITS-1:0] span;
   logic [CAP_BYTES-1:0] byte_ok;
   logic                 enough;

   // Clamp the configured length into 1..CAP_BYTES
   always_comb begin
      if (length_raw == '0) begin
         used_len = LEN_BITS'(1);
      end else if (length_raw > LEN_BITS'(CAP_BYTES)) begin
         used_len = LEN_BITS'(CAP_BYTES);
      end else begin
         used_len = length_raw;
      end
      span = SPAN_BITS'(used_len - LEN_BITS'(1));
   end

   // Compare each window byte with its aligned pattern byte; unused slots pass
   always_comb begin
      for (int j = 0; j < CAP_BYTES; j++) begin
         if (SPAN_BITS'(j) <= span) begin
            byte_ok[j] = (window[j] == pattern[span - SPAN_BITS'(j)]);
         end else begin
            byte_ok[j] = 1'b1;
         end
      end
   end

   assign enough = (32'(fill_count) >= 32'(used_len));
   assign status.hit  = enough && (&byte_ok);
   assign status.span = span;

endmodule

`default_nettype wire

// ----- sv/kmp_string_search_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports       Direction  Payload
// request   req_chan    in         text_byte[7:0], text_start
// response  rsp_chan    out        match_start[31:0]
// config    csr_chan    in         reg_index[1:0], wdata[63:0]
//
// One text byte per cycle is accepted while rsp_chan does not stall; a byte is
// registered in the input register and compared against the pattern window, and
// a match passes through the result register before it is valid on rsp_chan.
// The whole-window compare sits between the input register and the result
// register. Reset is synchronous and clears window count, position and valids.
// A stalled response holds the compare stage; the input register takes one
// more transaction and then holds req_chan off until the response drains.

module kmp_string_search_core (
   input logic clock,
   input logic reset,
   kmp_req_if.sink   req_chan,
   kmp_rsp_if.source rsp_chan,
   kmp_csr_if.sink   csr_chan
);
   import kmp_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   // Configuration registers
   logic [CSR_DATA_BITS-1:0] pattern_low_ff;
   logic [CSR_DATA_BITS-1:0] pattern_high_ff;
   logic [LEN_BITS-1:0]      pattern_len_ff;

   // Input register
   logic     s1_valid_ff;
   byte_type s1_byte_ff;
   logic     s1_start_ff;

   // Search state
   window_type               window_ff;
   window_type               window_in;
   logic [CNT_BITS-1:0]      count_ff;
   logic [CNT_BITS-1:0]      count_base;
   logic [CNT_BITS-1:0]      count_in;
   logic [POSITION_BITS-1:0] pos_ff;
   logic [POSITION_BITS-1:0] pos_base;
   logic [POSITION_BITS-1:0] pos_in;

   // Result register
   logic                  rsp_valid_ff;
   logic [MATCH_BITS-1:0] rsp_start_ff;
   logic [MATCH_BITS-1:0] rsp_start_in;

   logic             advance;
   pattern_type      pattern;
   match_status_type status;

   assign advance = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.match_start = rsp_start_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
         pattern_len_ff  <= LEN_BITS'(1);
      end else if (csr_chan.valid) begin
         unique case (csr_index_type'(csr_chan.reg_index))
            CSR_PATTERN_LOW:  pattern_low_ff  <= csr_chan.wdata;
            CSR_PATTERN_HIGH: pattern_high_ff <= csr_chan.wdata;
            CSR_PATTERN_LEN:  pattern_len_ff  <= csr_chan.wdata[LEN_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign pattern = pattern_type'({pattern_high_ff, pattern_low_ff});

   // Capture the incoming transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_byte_ff  <= req_chan.text_byte;
         s1_start_ff <= req_chan.text_start;
      end
   end

   // Shift the window and advance count and position
   always_comb begin
      count_base = s1_start_ff ? '0 : count_ff;
      pos_base   = s1_start_ff ? '0 : pos_ff;
      window_in  = window_type'({window_ff[PATTERN_BYTES-2:0], s1_byte_ff});
      if (count_base < CNT_BITS'(PATTERN_BYTES)) begin
         count_in = count_base + CNT_BITS'(1);
      end else begin
         count_in = count_base;
      end
      if (pos_base != POS_MAX) begin
         pos_in = pos_base + POSITION_BITS'(1);
      end else begin
         pos_in = pos_base;
      end
   end

   kmp_window_match u_match (
      .window     (window_in),
      .fill_count (count_in),
      .pattern    (pattern),
      .length_raw (pattern_len_ff),
      .status     (status)
   );

   assign rsp_start_in = MATCH_BITS'(pos_base - POSITION_BITS'(status.span));

   // Update search state; drop the window count after a match
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         count_ff  <= '0;
         pos_ff    <= '0;
      end else if (advance) begin
         window_ff <= window_in;
         count_ff  <= status.hit ? '0 : count_in;
         pos_ff    <= pos_in;
      end
   end

   // Hold the result until the response transaction completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= status.hit;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && status.hit) begin
         rsp_start_ff <= rsp_start_in;
      end
   end

   // A match always restarts the window count
   assert property (@(posedge clock) disable iff (reset)
      advance && status.hit |=> count_ff == '0)
      else $error("window count not cleared after match");

   // A new response only comes from a processed byte
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("response raised without a processed byte");

   // Position never moves back inside one text
   assert property (@(posedge clock) disable iff (reset)
      advance && !s1_start_ff |=> pos_ff >= $past(pos_ff))
      else $error("position moved backwards");

   // An empty input register always takes a transaction
   assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_chan.ready)
      else $error("input stalled while empty");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import kmp_pkg::*;

   logic clock;
   logic reset;

   kmp_req_if req_if();
   kmp_rsp_if rsp_if();
   kmp_csr_if csr_if();

   kmp_string_search_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   localparam longint unsigned POS_LIMIT = (64'd1 << POSITION_BITS) - 64'd1;
   localparam int RANDOM_ITEMS = 1200;

   // Mirror of the configuration registers
   pattern_type pat_bytes = '0;
   logic [4:0]  pat_len = 5'd1;

   // Mirror of the search state
   byte_type        recent [PATTERN_BYTES];
   int unsigned     window_fill = 0;
   longint unsigned next_pos = 0;

   // Expected match positions, oldest first
   logic [31:0] match_start_q [$];

   int unsigned error_count = 0;
   int unsigned sent_count = 0;
   int unsigned rsp_hold_cycles = 0;
   bit          no_idle = 1'b0;

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop
   initial begin
      #5000000;
      $display("== FAIL ==");
      $finish;
   end

   // Clamp the length register to the span actually compared
   function automatic int unsigned used_span();
      int unsigned span;
      span = (pat_len == 5'd0) ? 1 : pat_len;
      if (span > CAP_BYTES) span = CAP_BYTES;
      return span;
   endfunction

   // Append one expected match position
   function automatic void add_expected(input logic [31:0] start_pos);
      match_start_q = {match_start_q, start_pos};
   endfunction

   // Advance the state mirror by one text byte; return 1 on a match
   function automatic bit predict_match(input byte_type text_b, input bit text_s,
                                        output logic [31:0] start_pos);
      longint unsigned pos;
      int unsigned     span;
      bit              hit;
      start_pos = '0;
      if (text_s) begin
         window_fill = 0;
         next_pos = 0;
      end
      pos = next_pos;
      if (next_pos < POS_LIMIT) next_pos++;
      for (int i = PATTERN_BYTES - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = text_b;
      if (window_fill < PATTERN_BYTES) window_fill++;
      span = used_span();
      if (window_fill < span) return 1'b0;
      hit = 1'b1;
      for (int k = 0; k < span; k++) begin
         if (recent[span-1-k] != pat_bytes[k]) hit = 1'b0;
      end
      if (!hit) return 1'b0;
      window_fill = 0;
      start_pos = 32'(pos - longint'(span - 1));
      return 1'b1;
   endfunction

   // Offer one text byte after a random gap and hold it until taken
   task automatic send_text(input byte_type text_b, input bit text_s);
      int unsigned gap;
      logic [31:0] start_pos;
      gap = no_idle ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.text_byte  <= text_b;
      req_if.text_start <= text_s;
      do @(posedge clock); while (!req_if.ready);
      if (predict_match(text_b, text_s, start_pos)) add_expected(start_pos);
      sent_count++;
   endtask

   // Issue one register write; the caller drops valid after the last one
   task automatic write_csr(input csr_index_type idx, input logic [63:0] data);
      csr_if.valid     <= 1'b1;
      csr_if.reg_index <= idx;
      csr_if.wdata     <= data;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         CSR_PATTERN_LOW:  pat_bytes[7:0]  = data;
         CSR_PATTERN_HIGH: pat_bytes[15:8] = data;
         CSR_PATTERN_LEN:  pat_len         = data[4:0];
         default: ;
      endcase
   endtask

   // Drain all outstanding matches, then let the pipeline empty
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (match_start_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Reset pattern is one zero byte
   task automatic test_reset_defaults();
      send_text(8'h00, 1'b1);
      send_text(8'hFF, 1'b0);
   endtask

   // Full 16-byte pattern, length register above the cap
   task automatic test_long_pattern();
      pattern_type pat;
      logic [63:0] len_word;
      wait_idle();
      for (int k = 0; k < CFG_BYTES; k++) pat[k] = 8'($urandom);
      pat[0]  = 8'hFF;
      pat[15] = 8'h00;
      len_word = {$urandom, $urandom};
      len_word[4:0] = 5'd31;
      write_csr(CSR_PATTERN_LOW, pat[7:0]);
      write_csr(CSR_PATTERN_HIGH, pat[15:8]);
      write_csr(CSR_PATTERN_LEN, len_word);
      csr_if.valid <= 1'b0;
      for (int k = 0; k < CFG_BYTES; k++) send_text(pat[k], k == 0);
   endtask

   // Zero length behaves as one byte, back-to-back single-byte hits
   task automatic test_length_zero();
      wait_idle();
      write_csr(CSR_PATTERN_LEN, 64'd0);
      csr_if.valid <= 1'b0;
      send_text(pat_bytes[0], 1'b1);
      send_text(pat_bytes[0], 1'b0);
   endtask

   // Length change in mid-text, then a new text clearing a partial match
   task automatic test_length_change();
      wait_idle();
      write_csr(CSR_PATTERN_LEN, 64'd2);
      csr_if.valid <= 1'b0;
      send_text(pat_bytes[0], 1'b0);
      send_text(pat_bytes[1], 1'b0);
      send_text(pat_bytes[0], 1'b0);
      send_text(pat_bytes[1], 1'b1);
   endtask

   // Hold the response side off while every byte matches
   task automatic test_backpressure();
      wait_idle();
      write_csr(CSR_PATTERN_LOW, 64'h5A);
      write_csr(CSR_PATTERN_LEN, 64'd1);
      csr_if.valid <= 1'b0;
      rsp_hold_cycles = 300;
      no_idle = 1'b1;
      for (int n = 0; n < 48; n++) send_text(8'h5A, n == 0);
      no_idle = 1'b0;
   endtask

   // Phases of random pattern and text built mostly from pattern copies
   task automatic test_random_streams();
      byte_type    alpha [4];
      pattern_type pat;
      logic [63:0] len_word;
      int unsigned goal, phase_end, pick, span;
      bit          first;
      byte_type    text_b;
      goal = sent_count + RANDOM_ITEMS;
      foreach (alpha[i]) alpha[i] = 8'($urandom);
      while (sent_count < goal) begin
         wait_idle();
         no_idle = ($urandom_range(0, 5) == 0);
         len_word = {$urandom, $urandom};
         pick = $urandom_range(0, 9);
         case (pick)
            0:       len_word[4:0] = 5'd0;
            1:       len_word[4:0] = 5'd16;
            2:       len_word[4:0] = 5'($urandom_range(17, 31));
            3, 4:    len_word[4:0] = 5'($urandom_range(5, 15));
            default: len_word[4:0] = 5'($urandom_range(1, 4));
         endcase
         // Sometimes change only the length and keep the pattern bytes
         if ($urandom_range(0, 3) != 0) begin
            foreach (alpha[i]) alpha[i] = 8'($urandom);
            if ($urandom_range(0, 3) == 0) begin
               alpha[0] = 8'h00;
               alpha[1] = 8'hFF;
            end
            for (int k = 0; k < CFG_BYTES; k++) pat[k] = alpha[$urandom_range(0, 3)];
            write_csr(CSR_PATTERN_LOW, pat[7:0]);
            write_csr(CSR_PATTERN_HIGH, pat[15:8]);
         end
         write_csr(CSR_PATTERN_LEN, len_word);
         csr_if.valid <= 1'b0;

         phase_end = sent_count + $urandom_range(20, 80);
         first = ($urandom_range(0, 3) != 0);
         while (sent_count < phase_end) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               // Pattern copy, now and then with one byte spoiled
               span = used_span();
               for (int k = 0; k < span; k++) begin
                  text_b = pat_bytes[k];
                  if ($urandom_range(0, 19) == 0) text_b = alpha[$urandom_range(0, 3)];
                  send_text(text_b, first);
                  first = 1'b0;
               end
            end else if (pick < 9) begin
               repeat ($urandom_range(1, 6)) begin
                  send_text(alpha[$urandom_range(0, 3)], first);
                  first = 1'b0;
               end
            end else begin
               // Noise over the full byte range
               send_text(8'($urandom), first || ($urandom_range(0, 7) == 0));
               first = 1'b0;
            end
            if ($urandom_range(0, 49) == 0) first = 1'b1;
         end
      end
      no_idle = 1'b0;
   endtask

   // Accept results after random stalls and check them against the queue
   initial begin : match_checker
      int unsigned stall;
      logic [31:0] exp_start;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 16);
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         if (match_start_q.size() == 0) begin
            $error("match_start: expected none, actual %0d", rsp_if.match_start);
            error_count++;
         end else begin
            exp_start = match_start_q.pop_front();
            if (rsp_if.match_start !== exp_start) begin
               $error("match_start: expected %0d, actual %0d", exp_start,
                      rsp_if.match_start);
               error_count++;
            end
         end
      end
   end

   // Test sequence
   initial begin
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.text_byte  <= 8'h00;
      req_if.text_start <= 1'b0;
      csr_if.valid      <= 1'b0;
      csr_if.reg_index  <= CSR_PATTERN_LOW;
      csr_if.wdata      <= '0;
      foreach (recent[i]) recent[i] = 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_long_pattern();
      test_length_zero();
      test_length_change();
      test_backpressure();
      test_random_streams();

      wait_idle();
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
